[hw/rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg: swept box collision shared definitions
// Face normal codes and fixed result widths.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int HIT_TIME_WIDTH = 16;
  localparam int NORMAL_WIDTH   = 3;

  typedef enum logic [NORMAL_WIDTH-1:0] {
    NORMAL_NONE    = 3'd0,
    NORMAL_MINUS_X = 3'd1,
    NORMAL_PLUS_X  = 3'd2,
    NORMAL_MINUS_Y = 3'd3,
    NORMAL_PLUS_Y  = 3'd4
  } normal_e;

endpackage

[hw/rtl/sbc_if.sv]
// ----------------------------------------------------------------------------
// sbc_if: swept box collision channels
// Valid/ready channels for box pairs in and collision results out.
// ----------------------------------------------------------------------------
interface sbc_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] mover_min_x;
  logic signed [COORD_WIDTH-1:0] mover_min_y;
  logic signed [COORD_WIDTH-1:0] mover_max_x;
  logic signed [COORD_WIDTH-1:0] mover_max_y;
  logic signed [COORD_WIDTH-1:0] target_min_x;
  logic signed [COORD_WIDTH-1:0] target_min_y;
  logic signed [COORD_WIDTH-1:0] target_max_x;
  logic signed [COORD_WIDTH-1:0] target_max_y;
  logic signed [COORD_WIDTH-1:0] move_dx;
  logic signed [COORD_WIDTH-1:0] move_dy;
  logic                          target_one_sided;

  modport source (
    output valid, mover_min_x, mover_min_y, mover_max_x, mover_max_y,
           target_min_x, target_min_y, target_max_x, target_max_y,
           move_dx, move_dy, target_one_sided,
    input  ready
  );
  modport sink (
    input  valid, mover_min_x, mover_min_y, mover_max_x, mover_max_y,
           target_min_x, target_min_y, target_max_x, target_max_y,
           move_dx, move_dy, target_one_sided,
    output ready
  );
endinterface

interface sbc_out_if import sbc_pkg::*; #(
  parameter int COORD_WIDTH = 24
);
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [HIT_TIME_WIDTH-1:0] hit_time;
  logic signed [COORD_WIDTH-1:0]    contact_x;
  logic signed [COORD_WIDTH-1:0]    contact_y;
  logic [NORMAL_WIDTH-1:0]          normal_code;

  modport source (
    output valid, hit, hit_time, contact_x, contact_y, normal_code,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_time, contact_x, contact_y, normal_code,
    output ready
  );
endinterface

[hw/rtl/sbc_div.sv]
// ----------------------------------------------------------------------------
// sbc_div: pipelined restoring divider
// One quotient bit per stage, TIME_FRAC_BITS+2 stages; side data rides along.
// ----------------------------------------------------------------------------
module sbc_div import sbc_pkg::*; #(
  parameter int COORD_WIDTH    = 24,
  parameter int TIME_FRAC_BITS = 14,
  parameter int SIDE_WIDTH     = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic [COORD_WIDTH+TIME_FRAC_BITS+1:0]   num_i,
  input  logic [COORD_WIDTH:0]                    den_i,
  input  logic [SIDE_WIDTH-1:0]                   side_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [TIME_FRAC_BITS+1:0]               quo_o,
  output logic [SIDE_WIDTH-1:0]                   side_o
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = TIME_FRAC_BITS;
  localparam int NS = F + 2;
  localparam int UW = W + F + 2;

  logic [NS-1:0]   v_q;
  logic [NS:0]     rdy;
  logic [W-1:0]    r_q    [NS];
  logic [NS-1:0]   q_q    [NS];
  logic [UW-1:0]   u_q    [NS];
  logic [W:0]      y_q    [NS];
  logic [SIDE_WIDTH-1:0] side_q [NS];

  assign rdy[NS]  = ready_i;
  assign ready_o  = rdy[0];
  assign valid_o  = v_q[NS-1];
  assign quo_o    = q_q[NS-1];
  assign side_o   = side_q[NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                  v_in;
    logic [W-1:0]          r_in;
    logic [NS-1:0]         q_in;
    logic [UW-1:0]         u_in;
    logic [W:0]            y_in;
    logic [SIDE_WIDTH-1:0] s_in;
    logic [W:0]            sh;
    logic                  ge;
    logic [W-1:0]          r_d;
    logic [NS-1:0]         q_d;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = num_i[UW-1:F+2];
      assign q_in = '0;
      assign u_in = num_i;
      assign y_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
      assign q_in = q_q[i-1];
      assign u_in = u_q[i-1];
      assign y_in = y_q[i-1];
      assign s_in = side_q[i-1];
    end

    assign rdy[i] = !v_q[i] || rdy[i+1];

    always_comb begin
      sh  = {r_in, u_in[NS-1-i]};
      ge  = (sh >= y_in);
      r_d = ge ? W'(sh - y_in) : W'(sh);
      q_d = q_in;
      q_d[NS-1-i] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i]) begin
        r_q[i]    <= r_d;
        q_q[i]    <= q_d;
        u_q[i]    <= u_in;
        y_q[i]    <= y_in;
        side_q[i] <= s_in;
      end
    end
  end

endmodule

[hw/rtl/swept_box_collision_core.sv]
// ----------------------------------------------------------------------------
// swept_box_collision_core: swept AABB slab test, fixed point
// Throughput: one box pair per cycle unless the result channel stalls; slab setup,
// cross products, face select, a one-bit-per-stage divider and the contact
// multiply are all pipelined.
// Reset clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
module swept_box_collision_core import sbc_pkg::*; #(
  parameter int COORD_WIDTH    = 24,
  parameter int TIME_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbc_in_if.sink    in_i,
  sbc_out_if.source out_o
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = TIME_FRAC_BITS;
  localparam int PW = 2 * W + 3;
  localparam int UW = W + F + 2;
  localparam int LW = W + F + 4;
  localparam int SW = 4 * W + 3 + NORMAL_WIDTH;
  localparam logic [F+1:0] TIME_ONE = (F+2)'(1) << F;
  localparam logic signed [LW-1:0] CMAX = LW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [LW-1:0] CMIN = -CMAX - LW'(1);
  localparam logic signed [LW-1:0] RND  = LW'(1) <<< F;

  typedef struct packed {
    logic                  ub;
    logic                  bad;
    logic signed [W+1:0]   en;
    logic signed [W+1:0]   ex;
    logic [W-1:0]          den;
  } slab_t;

  typedef struct packed {
    logic signed [W:0]   msx;
    logic signed [W:0]   msy;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                os;
  } carry_t;

  function automatic slab_t build_slab(input logic signed [W-1:0] tlo, thi, mlo, mhi, d);
    logic signed [W:0]   a;
    logic signed [W:0]   b;
    logic signed [W+1:0] an;
    logic signed [W+1:0] bn;
    slab_t               s;
    a  = (W+1)'(thi) - (W+1)'(mlo);
    b  = (W+1)'(tlo) - (W+1)'(mhi);
    an = d[W-1] ? -(W+2)'(a) : (W+2)'(a);
    bn = d[W-1] ? -(W+2)'(b) : (W+2)'(b);
    s.ub  = (d == '0) && (a > 0) && (b < 0);
    s.bad = (d == '0) && !((a > 0) && (b < 0));
    s.en  = (an < bn) ? an : bn;
    s.ex  = (an < bn) ? bn : an;
    s.den = d[W-1] ? (~d + W'(1)) : d;
    return s;
  endfunction

  // stage 1: slabs
  logic   v1_q, v2_q, v3_q, v4_q, vm_q, vo_q;
  logic   rdy1, rdy2, rdy3, rdy4, rdym, rdyo;
  slab_t  sx1_q, sy1_q, sx2_q, sy2_q;
  carry_t c1_q, c2_q, c3_q, c4_q;
  logic   zero1_q;

  assign rdyo = !vo_q || out_o.ready;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sx1_q   <= build_slab(in_i.target_min_x, in_i.target_max_x,
                            in_i.mover_min_x, in_i.mover_max_x, in_i.move_dx);
      sy1_q   <= build_slab(in_i.target_min_y, in_i.target_max_y,
                            in_i.mover_min_y, in_i.mover_max_y, in_i.move_dy);
      zero1_q <= (in_i.move_dx == '0) && (in_i.move_dy == '0);
      c1_q.msx <= (W+1)'(in_i.mover_min_x) + (W+1)'(in_i.mover_max_x);
      c1_q.msy <= (W+1)'(in_i.mover_min_y) + (W+1)'(in_i.mover_max_y);
      c1_q.dx  <= in_i.move_dx;
      c1_q.dy  <= in_i.move_dy;
      c1_q.os  <= in_i.target_one_sided;
    end
  end

  // stage 2: cross products of slab times
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic                 miss2_q;

  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pa_q    <= PW'(sx1_q.en * $signed({1'b0, sy1_q.den}));
      pb_q    <= PW'(sy1_q.ex * $signed({1'b0, sx1_q.den}));
      pc_q    <= PW'(sy1_q.en * $signed({1'b0, sx1_q.den}));
      pd_q    <= PW'(sx1_q.ex * $signed({1'b0, sy1_q.den}));
      miss2_q <= zero1_q || sx1_q.bad || sy1_q.bad;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      c2_q    <= c1_q;
    end
  end

  // stage 3: overlap, exit and face select
  logic signed [W+1:0] n3_q;
  logic [W-1:0]        d3_q;
  normal_e             nrm3_q;
  logic                miss3_q;
  logic                bnd3, xface3, miss3_d;
  normal_e             nrm3_d;

  assign rdy2 = !v2_q || rdy3;

  always_comb begin
    bnd3    = !sx2_q.ub && !sy2_q.ub;
    xface3  = bnd3 ? (pa_q > pc_q) : sy2_q.ub;
    miss3_d = miss2_q
           || (bnd3 && ((pa_q > pb_q) || (pc_q > pd_q)))
           || (!sx2_q.ub && sx2_q.ex[W+1])
           || (!sy2_q.ub && sy2_q.ex[W+1]);
    if (xface3) begin
      nrm3_d = (c2_q.dx > 0) ? NORMAL_MINUS_X : NORMAL_PLUS_X;
    end else begin
      nrm3_d = (c2_q.dy > 0) ? NORMAL_MINUS_Y : NORMAL_PLUS_Y;
    end
    if (c2_q.os && nrm3_d != NORMAL_PLUS_Y) begin
      miss3_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      n3_q    <= xface3 ? sx2_q.en : sy2_q.en;
      d3_q    <= xface3 ? sx2_q.den : sy2_q.den;
      nrm3_q  <= nrm3_d;
      miss3_q <= miss3_d;
      c3_q    <= c2_q;
    end
  end

  // stage 4: range check and divider operands
  logic [UW-1:0]       u4_q;
  logic [W:0]          y4_q;
  normal_e             nrm4_q;
  logic                miss4_q;
  logic signed [W+2:0] nd4, dext4;

  assign rdy3 = !v3_q || rdy4;

  always_comb begin
    dext4 = $signed({3'b000, d3_q});
    nd4   = (W+3)'(n3_q) + dext4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      u4_q    <= (UW'(nd4) << (F + 1)) + UW'(d3_q);
      y4_q    <= {d3_q, 1'b0};
      nrm4_q  <= nrm3_q;
      miss4_q <= miss3_q || ((W+3)'(n3_q) < -dext4) || ((W+3)'(n3_q) > dext4);
      c4_q    <= c3_q;
    end
  end

  // divider: time = (n + d) * 2^(F+1) + d over 2d, offset by one
  logic              div_v, div_rdy;
  logic [F+1:0]      div_q;
  logic [SW-1:0]     div_side;
  logic signed [W:0]   dv_msx, dv_msy;
  logic signed [W-1:0] dv_dx, dv_dy;
  logic [NORMAL_WIDTH-1:0] dv_nrm;
  logic              dv_hit;

  assign rdy4 = !v4_q || div_rdy;

  sbc_div #(
    .COORD_WIDTH   (W),
    .TIME_FRAC_BITS(F),
    .SIDE_WIDTH    (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v4_q),
    .ready_o(div_rdy),
    .num_i  (u4_q),
    .den_i  (y4_q),
    .side_i ({c4_q.msx, c4_q.msy, c4_q.dx, c4_q.dy, nrm4_q, !miss4_q}),
    .valid_o(div_v),
    .ready_i(rdym),
    .quo_o  (div_q),
    .side_o (div_side)
  );

  assign {dv_msx, dv_msy, dv_dx, dv_dy, dv_nrm, dv_hit} = div_side;

  // stage m: contact multiply
  logic signed [F+1:0]   tq_q;
  logic signed [F+W+1:0] px_q, py_q;
  logic signed [W:0]     msx_q, msy_q;
  logic [NORMAL_WIDTH-1:0] nrm_q;
  logic                  hitm_q;
  logic signed [F+1:0]   tq_d;

  assign rdym = !vm_q || rdyo;
  assign tq_d = $signed(div_q - TIME_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (rdym) begin
      vm_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdym) begin
      tq_q   <= tq_d;
      px_q   <= (F+W+2)'(tq_d * dv_dx);
      py_q   <= (F+W+2)'(tq_d * dv_dy);
      msx_q  <= dv_msx;
      msy_q  <= dv_msy;
      nrm_q  <= dv_nrm;
      hitm_q <= dv_hit;
    end
  end

  // stage o: round, saturate, result register
  logic signed [LW-1:0]             sx_full, sy_full;
  logic signed [W-1:0]              cx_d, cy_d;
  logic                             hit_q;
  logic signed [HIT_TIME_WIDTH-1:0] ht_q;
  logic signed [W-1:0]              cx_q, cy_q;
  logic [NORMAL_WIDTH-1:0]          nrmo_q;

  always_comb begin
    sx_full = ((LW'(msx_q) <<< F) + (LW'(px_q) <<< 1) + RND) >>> (F + 1);
    sy_full = ((LW'(msy_q) <<< F) + (LW'(py_q) <<< 1) + RND) >>> (F + 1);
    if (sx_full > CMAX) begin
      cx_d = W'(CMAX);
    end else if (sx_full < CMIN) begin
      cx_d = W'(CMIN);
    end else begin
      cx_d = W'(sx_full);
    end
    if (sy_full > CMAX) begin
      cy_d = W'(CMAX);
    end else if (sy_full < CMIN) begin
      cy_d = W'(CMIN);
    end else begin
      cy_d = W'(sy_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdyo) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo) begin
      hit_q  <= hitm_q;
      ht_q   <= hitm_q ? HIT_TIME_WIDTH'(tq_q) : '0;
      cx_q   <= hitm_q ? cx_d : '0;
      cy_q   <= hitm_q ? cy_d : '0;
      nrmo_q <= hitm_q ? nrm_q : NORMAL_NONE;
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.hit         = hit_q;
  assign out_o.hit_time    = ht_q;
  assign out_o.contact_x   = cx_q;
  assign out_o.contact_y   = cy_q;
  assign out_o.normal_code = nrmo_q;

  // checks
  a_hit_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.hit |-> out_o.normal_code != NORMAL_NONE)
    else $error("hit without face");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> out_o.hit_time == '0 && out_o.contact_x == '0
      && out_o.contact_y == '0 && out_o.normal_code == NORMAL_NONE)
    else $error("miss with nonzero fields");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> v1_q && v2_q && v3_q && v4_q)
    else $error("input stalled with a bubble in the front stages");

endmodule

[bench/swept_box_collision_core_tb.sv]
// ----------------------------------------------------------------------------
// swept_box_collision_core_tb: self-checking bench for the swept box core
// Drives box pairs through the input channel, predicts each collision result
// with an independent slab-test model and compares every output transfer.
// ----------------------------------------------------------------------------
module swept_box_collision_core_tb;
  import sbc_pkg::*;

  localparam int CW  = 24;
  localparam int TFB = 14;
  localparam int LATENCY = TFB + 8;
  localparam int N_RANDOM = 1530;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct packed {
    logic signed [CW-1:0] mx0, my0, mx1, my1, tx0, ty0, tx1, ty1, dx, dy;
    logic                 one_sided;
  } box_pair_t;

  typedef struct packed {
    logic                             hit;
    logic signed [HIT_TIME_WIDTH-1:0] hit_time;
    logic signed [CW-1:0]             cx, cy;
    logic [NORMAL_WIDTH-1:0]          normal;
  } collision_t;

  logic clk_i, rst_ni;
  sbc_in_if  #(.COORD_WIDTH(CW)) in_i ();
  sbc_out_if #(.COORD_WIDTH(CW)) out_o ();

  swept_box_collision_core #(.COORD_WIDTH(CW), .TIME_FRAC_BITS(TFB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i.sink), .out_o(out_o.source)
  );

  box_pair_t  pair_q[$];
  collision_t expected_q[$];
  int         n_fail;
  bit         stim_done;
  bit         quiet;
  int         hold_at;
  bit         holding;
  int         src_gap, snk_gap;
  int         n_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic logic signed [CW-1:0] sat(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CW-1:0];
  endfunction

  // slab bounds; returns 0 when a zero-speed slab does not overlap the target
  function automatic bit slab(longint lo, longint hi, longint mlo, longint mhi,
                              longint d, output bit unb, output longint en,
                              output longint ex, output longint den);
    longint a, b;
    a = hi - mlo;
    b = lo - mhi;
    unb = 0; en = 0; ex = 0; den = 1;
    if (d == 0) begin
      if (a > 0 && b < 0) begin
        unb = 1;
        return 1;
      end
      return 0;
    end
    if (d < 0) begin
      a = -a; b = -b; d = -d;
    end
    en = (a < b) ? a : b;
    ex = (a < b) ? b : a;
    den = d;
    return 1;
  endfunction

  function automatic collision_t predict_collision(box_pair_t p);
    collision_t r;
    longint mx0, my0, mx1, my1, dx, dy;
    longint xe, xx, xd, ye, yx, yd, n, d, tq, half, cx, cy;
    bit xu, yu, xf;
    normal_e nrm;
    mx0 = p.mx0; my0 = p.my0; mx1 = p.mx1; my1 = p.my1; dx = p.dx; dy = p.dy;
    r = '0;
    r.normal = NORMAL_NONE;
    if (dx == 0 && dy == 0) return r;
    if (!slab(p.tx0, p.tx1, mx0, mx1, dx, xu, xe, xx, xd)) return r;
    if (!slab(p.ty0, p.ty1, my0, my1, dy, yu, ye, yx, yd)) return r;
    if (!xu && !yu) begin
      if (xe * yd > yx * xd || ye * xd > xx * yd) return r;
      xf = xe * yd > ye * xd;
    end else begin
      xf = yu;
    end
    if ((!xu && xx < 0) || (!yu && yx < 0)) return r;
    if (xf) begin
      n = xe; d = xd;
      nrm = (dx > 0) ? NORMAL_MINUS_X : NORMAL_PLUS_X;
    end else begin
      n = ye; d = yd;
      nrm = (dy > 0) ? NORMAL_MINUS_Y : NORMAL_PLUS_Y;
    end
    if (p.one_sided && nrm != NORMAL_PLUS_Y) return r;
    if (n < -d || n > d) return r;
    half = 64'sd1 <<< TFB;
    tq = fdiv(2 * n * half + d, 2 * d);
    cx = fdiv((mx0 + mx1) * half + 2 * tq * dx + half, 2 * half);
    cy = fdiv((my0 + my1) * half + 2 * tq * dy + half, 2 * half);
    r.hit = 1'b1;
    r.hit_time = tq[HIT_TIME_WIDTH-1:0];
    r.cx = sat(cx);
    r.cy = sat(cy);
    r.normal = nrm;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed(CW'($urandom_range(0, 8000))) - 4000);
      2: return $signed(CW'($urandom_range(0, 1))) ? CMAX[CW-1:0] : CMIN[CW-1:0];
      default: return CW'($signed(CW'($urandom_range(0, 200000))) - 100000);
    endcase
  endfunction

  function automatic box_pair_t make_pair(longint mx, longint my, longint mw,
                                          longint mh, longint tx, longint ty,
                                          longint tw, longint th, longint dx,
                                          longint dy, bit os);
    box_pair_t p;
    p.mx0 = CW'(mx); p.my0 = CW'(my); p.mx1 = CW'(mx + mw); p.my1 = CW'(my + mh);
    p.tx0 = CW'(tx); p.ty0 = CW'(ty); p.tx1 = CW'(tx + tw); p.ty1 = CW'(ty + th);
    p.dx = CW'(dx); p.dy = CW'(dy); p.one_sided = os;
    return p;
  endfunction

  // mostly boxes near each other with a displacement that can reach the target
  function automatic box_pair_t random_pair();
    box_pair_t p;
    longint mx, my, tx, ty;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      p = {CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
           CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
           CW'($urandom), CW'($urandom), 1'($urandom)};
      return p;
    end
    if (k == 1) begin
      p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
           rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
           1'($urandom)};
      return p;
    end
    mx = $signed(32'($urandom_range(0, 20000))) - 10000;
    my = $signed(32'($urandom_range(0, 20000))) - 10000;
    tx = mx + $signed(32'($urandom_range(0, 12000))) - 6000;
    ty = my + $signed(32'($urandom_range(0, 12000))) - 6000;
    p = make_pair(mx, my, $urandom_range(0, 2000), $urandom_range(0, 2000),
                  tx, ty, $urandom_range(0, 4000), $urandom_range(0, 4000),
                  $signed(32'($urandom_range(0, 16000))) - 8000,
                  $signed(32'($urandom_range(0, 16000))) - 8000,
                  $urandom_range(0, 3) == 0);
    if (k == 2) p.dx = '0;
    if (k == 3) p.dy = '0;
    if (k == 4) begin
      p.mx0 = CW'(p.mx0 + 32'sd8000000); p.mx1 = CW'(p.mx1 + 32'sd8000000);
      p.tx0 = CW'(p.tx0 + 32'sd8000000); p.tx1 = CW'(p.tx1 + 32'sd8000000);
      p.dx = CW'($signed(32'($urandom_range(0, 1000000))) - 500000);
    end
    return p;
  endfunction

  initial begin
    box_pair_t p;
    n_fail = 0; stim_done = 0; quiet = 0;
    hold_at = $urandom_range(300, 900);
    rst_ni = 1'b0;
    // directed
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 0, 256, 256, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 0, 256, 256, 2000, 0, 0));
    pair_q.push_back(make_pair(2000, 0, 256, 256, 1000, 0, 256, 256, -2000, 0, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 0, 1000, 256, 256, 0, 2000, 0));
    pair_q.push_back(make_pair(0, 2000, 256, 256, 0, 1000, 256, 256, 0, -2000, 0));
    pair_q.push_back(make_pair(0, 2000, 256, 256, 0, 1000, 256, 256, 0, -2000, 1));
    pair_q.push_back(make_pair(0, 0, 256, 256, 0, 1000, 256, 256, 0, 2000, 1));
    pair_q.push_back(make_pair(0, 0, 256, 256, 256, 0, 256, 256, 0, 100, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 0, 256, 256, 100, 0, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 0, 256, 256, -2000, 0, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 2000, 256, 256, 1000, 0, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 100, 100, 256, 256, 300, 300, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 1000, 256, 256, 1000, 1000, 0));
    pair_q.push_back(make_pair(0, 0, -256, -256, 1000, 0, -256, 256, 2000, 7, 0));
    pair_q.push_back(make_pair(0, 0, 256, 256, 1000, 0, 256, 256, 1, 1, 0));
    p = {CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMIN[CW-1:0],
         CMIN[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], 1'b0};
    pair_q.push_back(p);
    p = {CMIN[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], CMAX[CW-1:0],
         CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], 1'b1};
    pair_q.push_back(p);
    pair_q.push_back(make_pair(8000000, 8000000, 100000, 100000, 8300000, 8300000,
                               80000, 80000, 400000, 400000, 0));
    pair_q.push_back(make_pair(-8300000, 0, 100, 100, -8388000, 0, 10, 100,
                               -100000, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) pair_q.push_back(random_pair());
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pair_q.size() == 0 && !in_i.valid);
    quiet = 1;
    stim_done = 1;
    wait (expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      {in_i.mover_min_x, in_i.mover_min_y, in_i.mover_max_x, in_i.mover_max_y,
       in_i.target_min_x, in_i.target_min_y, in_i.target_max_x, in_i.target_max_y,
       in_i.move_dx, in_i.move_dy, in_i.target_one_sided} <= '0;
      src_gap <= 0; n_sent <= 0; holding <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_q.push_back(predict_collision(
          {in_i.mover_min_x, in_i.mover_min_y, in_i.mover_max_x, in_i.mover_max_y,
           in_i.target_min_x, in_i.target_min_y, in_i.target_max_x,
           in_i.target_max_y, in_i.move_dx, in_i.move_dy, in_i.target_one_sided}));
      end
      if (!in_i.valid || in_i.ready) begin
        if (n_sent == hold_at && !holding) begin
          holding <= 1;
          in_i.valid <= 1'b0;
        end else if (holding && expected_q.size() != 0) begin
          in_i.valid <= 1'b0;
        end else if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_i.valid <= 1'b0;
        end else if (pair_q.size() != 0) begin
          {in_i.mover_min_x, in_i.mover_min_y, in_i.mover_max_x, in_i.mover_max_y,
           in_i.target_min_x, in_i.target_min_y, in_i.target_max_x,
           in_i.target_max_y, in_i.move_dx, in_i.move_dy,
           in_i.target_one_sided} <= pair_q.pop_front();
          in_i.valid <= 1'b1;
          n_sent <= n_sent + 1;
          if (holding) begin
            hold_at <= -1;
            holding <= 0;
          end
          if (pair_q.size() > 150 && $urandom_range(0, 9) == 0)
            src_gap <= $urandom_range(1, 13);
        end else begin
          in_i.valid <= 1'b0;
        end
      end
    end
  end

  // sink side and checking
  always @(posedge clk_i or negedge rst_ni) begin
    collision_t got, exp_r;
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        got = {out_o.hit, out_o.hit_time, out_o.contact_x, out_o.contact_y,
               out_o.normal_code};
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          n_fail++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, got.hit); n_fail++;
          end
          if (got.hit_time !== exp_r.hit_time) begin
            $error("hit_time: expected %0d, got %0d", exp_r.hit_time, got.hit_time);
            n_fail++;
          end
          if (got.cx !== exp_r.cx) begin
            $error("contact_x: expected %0d, got %0d", exp_r.cx, got.cx); n_fail++;
          end
          if (got.cy !== exp_r.cy) begin
            $error("contact_y: expected %0d, got %0d", exp_r.cy, got.cy); n_fail++;
          end
          if (got.normal !== exp_r.normal) begin
            $error("normal_code: expected %0d, got %0d", exp_r.normal, got.normal);
            n_fail++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_o.ready <= 1'b0;
      end else if (!quiet && pair_q.size() > 150 && $urandom_range(0, 11) == 0) begin
        snk_gap <= $urandom_range(0, 12);
        out_o.ready <= 1'b0;
      end else begin
        out_o.ready <= 1'b1;
      end
    end
  end

endmodule
